### rtl/core/fsns_pkg.sv
package fsns_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int SUM_BITS    = SAMPLE_BITS + 2;
    localparam int MAX_COLS    = 1024;
    localparam int MAX_ROWS    = 1024;
    localparam int COL_BITS    = $clog2(MAX_COLS);
    localparam int ROW_BITS    = $clog2(MAX_ROWS);
    localparam int IDX_BITS    = 10;

    localparam int CFG_BITS     = 11;
    localparam int CFG_IDX_BITS = 2;
    localparam int ROWS_RESET   = 4;
    localparam int COLS_RESET   = 5;

    localparam int PEND_VERT = 0;
    localparam int PEND_LEFT = 1;
    localparam int PEND_LAST = 2;
    localparam int PEND_BITS = 3;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [SUM_BITS-1:0]    sum_t;
    typedef logic [IDX_BITS-1:0]           out_idx_t;
    typedef logic [ROW_BITS-1:0]           row_t;
    typedef logic [COL_BITS-1:0]           col_t;
    typedef logic [CFG_BITS-1:0]           cfg_data_t;
    typedef logic [CFG_IDX_BITS-1:0]       cfg_idx_t;
    typedef logic [PEND_BITS-1:0]          pend_t;

    localparam cfg_idx_t REG_FRAME_ROWS = cfg_idx_t'(0);
    localparam cfg_idx_t REG_FRAME_COLS = cfg_idx_t'(1);

    typedef struct packed {
        sum_t     neighbor_sum;
        out_idx_t out_row;
        out_idx_t out_col;
        logic     run_last;
        logic     frame_last;
    } result_t;

    typedef struct packed {
        logic    en;
        logic    par;
        col_t    addr;
        col_t    addr_next;
        sample_t data;
    } line_req_t;

    typedef struct packed {
        sample_t up;
        sample_t right;
    } line_rsp_t;

endpackage

### rtl/core/fsns_stream_if.sv
interface fsns_in_if;
    logic              valid;
    logic              ready;
    fsns_pkg::sample_t sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

interface fsns_out_if;
    logic               valid;
    logic               ready;
    fsns_pkg::sum_t     neighbor_sum;
    fsns_pkg::out_idx_t out_row;
    fsns_pkg::out_idx_t out_col;
    logic               run_last;
    logic               frame_last;

    modport source (output valid, output neighbor_sum, output out_row, output out_col,
                    output run_last, output frame_last, input ready);
    modport sink (input valid, input neighbor_sum, input out_row, input out_col,
                  input run_last, input frame_last, output ready);
endinterface

### rtl/core/four_neighbor_sum_stencil_unit.sv
// A sample enters the compute stage register; its first result is offered from the output
// buffer. Throughput: one sample per cycle while each sample yields at most one result and
// the output buffer has room; a sample with more results holds the input until the last
// is pushed. Row 0 yields none and later rows one each; the final row adds one after its
// first column and one more on its last. Reset clears the counters, the pipeline and the
// output buffer, and sets a 4 x 5 frame. Line stores are not cleared; row 0 ignores them.
module four_neighbor_sum_stencil_unit (
    input  logic                clk,
    input  logic                rst_n,
    fsns_in_if.sink             in_ch,
    fsns_out_if.source          out_ch,
    input  logic                cfg_we,
    input  fsns_pkg::cfg_idx_t  cfg_index,
    input  fsns_pkg::cfg_data_t cfg_data
);

    typedef struct packed {
        fsns_pkg::sample_t sample;
        fsns_pkg::row_t    row;
        fsns_pkg::col_t    col;
        logic              has_up;
        logic              has_vert;
        logic              has_right;
        logic              col_ge1;
        logic              col_ge2;
    } stage_t;

    fsns_pkg::row_t      rows_last_reg;
    fsns_pkg::row_t      rows_last_next;
    fsns_pkg::col_t      cols_last_reg;
    fsns_pkg::col_t      cols_last_next;
    fsns_pkg::row_t      row_cnt_reg;
    fsns_pkg::row_t      row_cnt_next;
    fsns_pkg::col_t      col_cnt_reg;
    fsns_pkg::col_t      col_cnt_next;
    logic                s1_valid_reg;
    logic                s1_valid_next;
    fsns_pkg::pend_t     pend_reg;
    fsns_pkg::pend_t     pend_next;
    stage_t              s1_reg;
    fsns_pkg::sample_t   nb_c_reg;
    fsns_pkg::sample_t   nb_cm1_reg;
    fsns_pkg::sample_t   cur_m1_reg;
    fsns_pkg::sample_t   cur_m2_reg;
    fsns_pkg::sample_t   col0_reg;

    logic                cfg_hit;
    logic                in_fire;
    logic                last_col;
    logic                final_row;
    fsns_pkg::pend_t     new_pend;
    stage_t              s0;
    fsns_pkg::pend_t     pick;
    fsns_pkg::pend_t     rest;
    logic                can_push;
    logic                emit;
    logic                s1_retire;
    fsns_pkg::line_req_t line_req;
    fsns_pkg::line_rsp_t line_rsp;
    fsns_pkg::sum_t      t_up;
    fsns_pkg::sum_t      t_left;
    fsns_pkg::sum_t      t_right;
    fsns_pkg::sum_t      t_down;
    fsns_pkg::result_t   res;

    assign cfg_hit = cfg_we && (cfg_index == fsns_pkg::REG_FRAME_ROWS ||
                                cfg_index == fsns_pkg::REG_FRAME_COLS);

    always_comb
    begin
        rows_last_next = rows_last_reg;
        cols_last_next = cols_last_reg;
        if (cfg_we && cfg_index == fsns_pkg::REG_FRAME_ROWS)
        begin
            if (cfg_data == '0)
                rows_last_next = '0;
            else if (cfg_data > fsns_pkg::cfg_data_t'(fsns_pkg::MAX_ROWS))
                rows_last_next = fsns_pkg::row_t'(fsns_pkg::MAX_ROWS - 1);
            else
                rows_last_next = fsns_pkg::row_t'(cfg_data - fsns_pkg::cfg_data_t'(1));
        end
        if (cfg_we && cfg_index == fsns_pkg::REG_FRAME_COLS)
        begin
            if (cfg_data == '0)
                cols_last_next = '0;
            else if (cfg_data > fsns_pkg::cfg_data_t'(fsns_pkg::MAX_COLS))
                cols_last_next = fsns_pkg::col_t'(fsns_pkg::MAX_COLS - 1);
            else
                cols_last_next = fsns_pkg::col_t'(cfg_data - fsns_pkg::cfg_data_t'(1));
        end
    end

    assign last_col  = (col_cnt_reg == cols_last_reg);
    assign final_row = (row_cnt_reg == rows_last_reg);

    always_comb
    begin
        s0.sample    = in_ch.sample;
        s0.row       = row_cnt_reg;
        s0.col       = col_cnt_reg;
        s0.has_up    = (row_cnt_reg[fsns_pkg::ROW_BITS-1:1] != '0);
        s0.has_vert  = (row_cnt_reg != '0);
        s0.has_right = !last_col;
        s0.col_ge1   = (col_cnt_reg != '0);
        s0.col_ge2   = (col_cnt_reg[fsns_pkg::COL_BITS-1:1] != '0);
        new_pend[fsns_pkg::PEND_VERT] = s0.has_vert;
        new_pend[fsns_pkg::PEND_LEFT] = final_row && s0.col_ge1;
        new_pend[fsns_pkg::PEND_LAST] = final_row && last_col;
    end

    assign in_ch.ready = !s1_valid_reg || s1_retire;
    assign in_fire     = in_ch.valid && in_ch.ready;

    always_comb
    begin
        row_cnt_next = row_cnt_reg;
        col_cnt_next = col_cnt_reg;
        if (cfg_hit)
        begin
            row_cnt_next = '0;
            col_cnt_next = '0;
        end
        else if (in_fire)
        begin
            if (last_col)
            begin
                col_cnt_next = '0;
                row_cnt_next = final_row ? '0 : row_cnt_reg + fsns_pkg::row_t'(1);
            end
            else
            begin
                col_cnt_next = col_cnt_reg + fsns_pkg::col_t'(1);
            end
        end
    end

    always_comb
    begin
        line_req.en        = in_fire;
        line_req.par       = row_cnt_reg[0];
        line_req.addr      = col_cnt_reg;
        line_req.addr_next = col_cnt_reg + fsns_pkg::col_t'(1);
        line_req.data      = in_ch.sample;
    end

    fsns_line_mem u_line_mem (
        .clk (clk),
        .req (line_req),
        .rsp (line_rsp)
    );

    // Results of one sample leave in order: the row above, then the left and last
    // positions of the final row.
    assign pick      = pend_reg & (~pend_reg + fsns_pkg::pend_t'(1));
    assign rest      = pend_reg & ~pick;
    assign emit      = s1_valid_reg && (pend_reg != '0) && can_push;
    assign s1_retire = s1_valid_reg && (rest == '0) && ((pend_reg == '0) || can_push);

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        pend_next     = pend_reg;
        if (in_fire)
        begin
            s1_valid_next = 1'b1;
            pend_next     = new_pend;
        end
        else if (s1_retire)
        begin
            s1_valid_next = 1'b0;
            pend_next     = '0;
        end
        else if (emit)
        begin
            pend_next = rest;
        end
    end

    always_comb
    begin
        t_up    = '0;
        t_left  = '0;
        t_right = '0;
        t_down  = '0;
        res.out_row = fsns_pkg::out_idx_t'(s1_reg.row);
        res.out_col = fsns_pkg::out_idx_t'(s1_reg.col);
        if (pick[fsns_pkg::PEND_VERT])
        begin
            res.out_row = fsns_pkg::out_idx_t'(s1_reg.row - fsns_pkg::row_t'(1));
            if (s1_reg.has_up)
                t_up = fsns_pkg::sum_t'(line_rsp.up);
            if (s1_reg.col_ge1)
                t_left = fsns_pkg::sum_t'(nb_cm1_reg);
            if (s1_reg.has_right)
                t_right = fsns_pkg::sum_t'(line_rsp.right);
            t_down = fsns_pkg::sum_t'(s1_reg.sample);
        end
        else if (pick[fsns_pkg::PEND_LEFT])
        begin
            res.out_col = fsns_pkg::out_idx_t'(s1_reg.col - fsns_pkg::col_t'(1));
            if (s1_reg.has_vert)
                t_up = fsns_pkg::sum_t'(nb_cm1_reg);
            if (s1_reg.col_ge2)
                t_left = fsns_pkg::sum_t'(cur_m2_reg);
            t_right = fsns_pkg::sum_t'(s1_reg.sample);
        end
        else
        begin
            if (s1_reg.has_vert)
                t_up = fsns_pkg::sum_t'(nb_c_reg);
            if (s1_reg.col_ge1)
                t_left = fsns_pkg::sum_t'(cur_m1_reg);
        end
        res.neighbor_sum = t_up + t_left + t_right + t_down;
        res.run_last     = (rest == '0);
        res.frame_last   = pick[fsns_pkg::PEND_LAST];
    end

    fsns_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (emit),
        .push_data (res),
        .can_push  (can_push),
        .out_ch    (out_ch)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_last_reg <= fsns_pkg::row_t'(fsns_pkg::ROWS_RESET - 1);
            cols_last_reg <= fsns_pkg::col_t'(fsns_pkg::COLS_RESET - 1);
            row_cnt_reg   <= '0;
            col_cnt_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            pend_reg      <= '0;
        end
        else
        begin
            rows_last_reg <= rows_last_next;
            cols_last_reg <= cols_last_next;
            row_cnt_reg   <= row_cnt_next;
            col_cnt_reg   <= col_cnt_next;
            s1_valid_reg  <= s1_valid_next;
            pend_reg      <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_reg <= s0;
        end
    end

    // The window of the row above slides by one column per sample. The first sample
    // of each row is kept so the next row can start its window.
    always_ff @(posedge clk)
    begin
        if (s1_retire)
        begin
            cur_m1_reg <= s1_reg.sample;
            cur_m2_reg <= cur_m1_reg;
            nb_cm1_reg <= nb_c_reg;
            if (!s1_reg.col_ge1)
                col0_reg <= s1_reg.sample;
            if (!s1_reg.has_right)
                nb_c_reg <= s1_reg.col_ge1 ? col0_reg : s1_reg.sample;
            else
                nb_c_reg <= line_rsp.right;
        end
    end

    a_stage_load: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> s1_valid_reg)
        else $error("Accepted request did not reach the compute stage.");

    a_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> pend_reg == '0)
        else $error("Pending results left without a request in the compute stage.");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (col_cnt_reg <= cols_last_reg) && (row_cnt_reg <= rows_last_reg))
        else $error("Position counters ran past the frame size.");

    a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.frame_last |-> out_ch.run_last)
        else $error("Frame end result is not the last result of its request.");

endmodule

### rtl/core/fsns_line_mem.sv
module fsns_line_mem (
    input  logic                 clk,
    input  fsns_pkg::line_req_t  req,
    output fsns_pkg::line_rsp_t  rsp
);

    // Bank A holds even rows and bank B odd rows. The bank of the current row is
    // read before it is written, so it returns the sample two rows up.
    fsns_pkg::sample_t bank_a_reg [fsns_pkg::MAX_COLS];
    fsns_pkg::sample_t bank_b_reg [fsns_pkg::MAX_COLS];
    fsns_pkg::sample_t q_a_reg;
    fsns_pkg::sample_t q_b_reg;
    logic              par_reg;
    fsns_pkg::col_t    addr_a;
    fsns_pkg::col_t    addr_b;

    assign addr_a = req.par ? req.addr_next : req.addr;
    assign addr_b = req.par ? req.addr : req.addr_next;

    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            q_a_reg <= bank_a_reg[addr_a];
            if (!req.par)
            begin
                bank_a_reg[addr_a] <= req.data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            q_b_reg <= bank_b_reg[addr_b];
            if (req.par)
            begin
                bank_b_reg[addr_b] <= req.data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            par_reg <= req.par;
        end
    end

    assign rsp.up    = par_reg ? q_b_reg : q_a_reg;
    assign rsp.right = par_reg ? q_a_reg : q_b_reg;

endmodule

### rtl/core/fsns_out_buf.sv
module fsns_out_buf (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  fsns_pkg::result_t   push_data,
    output logic                can_push,
    fsns_out_if.source          out_ch
);

    fsns_pkg::result_t slot_reg [2];
    logic              wr_ptr_reg;
    logic              wr_ptr_next;
    logic              rd_ptr_reg;
    logic              rd_ptr_next;
    logic [1:0]        count_reg;
    logic [1:0]        count_next;
    logic              pop;
    fsns_pkg::result_t head;

    assign head     = slot_reg[rd_ptr_reg];
    assign pop      = out_ch.valid && out_ch.ready;
    assign can_push = (count_reg != 2'd2);

    assign out_ch.valid        = (count_reg != 2'd0);
    assign out_ch.neighbor_sum = head.neighbor_sum;
    assign out_ch.out_row      = head.out_row;
    assign out_ch.out_col      = head.out_col;
    assign out_ch.run_last     = head.run_last;
    assign out_ch.frame_last   = head.frame_last;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
